### rtl/rcw_pkg.sv
package rcw_pkg;

  localparam int DIST_W = 24;
  localparam int HGT_W  = 16;
  localparam int ROW_W  = 10;
  localparam int COL_W  = 10;
  localparam int STEP_W = 23;
  localparam int START_W = 22;

  localparam logic [DIST_W-1:0]  DIST_MAX  = '1;
  localparam logic [HGT_W-1:0]   HGT_MAX   = '1;
  localparam logic [STEP_W-1:0]  STEP_MAX  = '1;
  localparam logic [START_W-1:0] START_MAX = '1;

  // texture numbers
  localparam logic [1:0] TSEL_X_NEG = 2'd0;
  localparam logic [1:0] TSEL_X_POS = 2'd1;
  localparam logic [1:0] TSEL_Y_NEG = 2'd2;
  localparam logic [1:0] TSEL_Y_POS = 2'd3;

  // travels with the distance divider
  typedef struct packed {
    logic              ray0;
    logic              neg;
    logic              dsat;
    logic [1:0]        tsel;
    logic              mirror;
    logic [15:0]       eye_lo;
    logic signed [17:0] ray_o;
  } rcw_sba_t;

  // travels with the height divider
  typedef struct packed {
    logic [DIST_W-1:0] wdist;
    logic              err;
    logic              dz;
    logic              hsat;
    logic [1:0]        tsel;
    logic [COL_W-1:0]  col;
  } rcw_sbb_t;

  // travels with the texture step divider
  typedef struct packed {
    logic [DIST_W-1:0] wdist;
    logic [HGT_W-1:0]  hgt;
    logic [ROW_W-1:0]  first;
    logic [ROW_W-1:0]  last;
    logic [1:0]        tsel;
    logic [COL_W-1:0]  col;
    logic              err;
    logic              hz;
    logic              ssat;
    logic [15:0]       off;
  } rcw_sbc_t;

endpackage

### rtl/raycast_column_wall_texture_setup_core.sv
// throughput: one column per cycle; three chains of restoring divider cells
// (24, 16 and 23 cells, one quotient bit each) run fully pipelined
// the whole pipeline holds while a result waits unaccepted at the output
// reset: rst_n low synchronously clears all valid flags, no results pending
module raycast_column_wall_texture_setup_core
  import rcw_pkg::*;
#(
  parameter int SCREEN_ROWS = 512,
  parameter int TEX_COLS    = 64,
  parameter int TEX_ROWS    = 64
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // cell_x, cell_y, dir_sign_x, dir_sign_y, eye_x, eye_y, ray_x, ray_y
  input  logic [103:0] in_tdata,
  // hit_side
  input  logic [0:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // wall_distance, slice_height, row_first, row_last, texture_select,
  // texture_column, texture_step, texture_start, zero pad
  output logic [119:0] out_tdata,
  // div_error
  output logic [0:0]   out_tuser
);

  localparam int SBA_W = $bits(rcw_sba_t);
  localparam int SBB_W = $bits(rcw_sbb_t);
  localparam int SBC_W = $bits(rcw_sbc_t);
  localparam logic [16:0] SR17   = 17'(SCREEN_ROWS);
  localparam logic [16:0] HALF17 = 17'(SCREEN_ROWS / 2);
  localparam logic [10:0] TCV    = 11'(TEX_COLS);
  localparam logic [10:0] TRV    = 11'(TEX_ROWS);

  logic en;
  logic out_valid_r;

  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;

  // input register
  logic         s0_v_r;
  logic         s0_side_r;
  logic [103:0] s0_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
    end else if (en) begin
      s0_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_side_r <= in_tuser[0];
      s0_data_r <= in_tdata;
    end
  end

  // distance setup
  logic [7:0]         cx, cy, hcell;
  logic [1:0]         sx, sy, sgn;
  logic [23:0]        ex, ey, eye, eye_o;
  logic signed [17:0] rx, ry, ray, ray_o;
  logic signed [25:0] num;
  logic [24:0]        anum;
  logic [17:0]        aray;
  rcw_sba_t           sba_in, sba_out;
  logic               ca_v;
  logic [23:0]        ca_q;
  logic [SBA_W-1:0]   sba_bits;

  always_comb begin
    cx    = s0_data_r[7:0];
    cy    = s0_data_r[15:8];
    sx    = s0_data_r[17:16];
    sy    = s0_data_r[19:18];
    ex    = s0_data_r[43:20];
    ey    = s0_data_r[67:44];
    rx    = $signed(s0_data_r[85:68]);
    ry    = $signed(s0_data_r[103:86]);
    hcell = s0_side_r ? cy : cx;
    sgn   = s0_side_r ? sy : sx;
    eye   = s0_side_r ? ey : ex;
    ray   = s0_side_r ? ry : rx;
    eye_o = s0_side_r ? ex : ey;
    ray_o = s0_side_r ? rx : ry;
    num   = $signed({2'b00, hcell, 16'h0000}) - $signed({2'b00, eye})
          + (sgn[1] ? 26'sd65536 : 26'sd0);
    anum  = num[25] ? 25'(-num) : num[24:0];
    aray  = ray[17] ? 18'(-ray) : 18'(ray);
    sba_in.ray0   = (ray == 18'sd0);
    sba_in.neg    = num[25] ^ ray[17];
    sba_in.dsat   = {1'b0, anum} >= {aray, 8'h00};
    sba_in.tsel   = s0_side_r ? (ray[17] ? TSEL_Y_NEG : TSEL_Y_POS)
                              : (ray[17] ? TSEL_X_NEG : TSEL_X_POS);
    sba_in.mirror = (!s0_side_r && rx > 18'sd0) || (s0_side_r && ry[17]);
    sba_in.eye_lo = eye_o[15:0];
    sba_in.ray_o  = ray_o;
  end

  rcw_div_chain #(.DW(18), .QW(DIST_W), .SW(SBA_W)) u_div_dist (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .v_in  (s0_v_r),
    .rem_in({1'b0, anum[24:8]}),
    .dvs_in(aray),
    .nb_in ({anum[7:0], 16'h0000}),
    .sb_in (sba_in),
    .v_out (ca_v),
    .q_out (ca_q),
    .sb_out(sba_bits)
  );

  assign sba_out = rcw_sba_t'(sba_bits);

  // distance result and hit point product
  logic [DIST_W-1:0]  dist_a;
  logic               s1_v_r;
  logic [DIST_W-1:0]  s1_dist_r;
  logic               s1_err_r;
  logic [1:0]         s1_tsel_r;
  logic               s1_mirror_r;
  logic [15:0]        s1_eye_lo_r;
  logic signed [42:0] s1_prod_r;

  always_comb begin
    if (sba_out.ray0 || (sba_out.dsat && !sba_out.neg)) begin
      dist_a = DIST_MAX;
    end else if (sba_out.neg) begin
      dist_a = '0;
    end else begin
      dist_a = ca_q;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= ca_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_dist_r   <= dist_a;
      s1_err_r    <= sba_out.ray0;
      s1_tsel_r   <= sba_out.tsel;
      s1_mirror_r <= sba_out.mirror;
      s1_eye_lo_r <= sba_out.eye_lo;
      s1_prod_r   <= $signed({1'b0, dist_a}) * sba_out.ray_o;
    end
  end

  // texture column and height setup
  logic [15:0]      frac;
  logic [26:0]      colm;
  logic [COL_W-1:0] colraw;
  rcw_sbb_t         sbb_in, sbb_out;
  logic             cb_v;
  logic [HGT_W-1:0] cb_q;
  logic [SBB_W-1:0] sbb_bits;

  always_comb begin
    frac   = s1_eye_lo_r + s1_prod_r[31:16];
    colm   = frac * TCV;
    colraw = colm[16+COL_W-1:16];
    sbb_in.wdist = s1_dist_r;
    sbb_in.err   = s1_err_r;
    sbb_in.dz    = (s1_dist_r == '0);
    sbb_in.hsat  = s1_dist_r <= 24'(SCREEN_ROWS);
    sbb_in.tsel  = s1_tsel_r;
    sbb_in.col   = s1_mirror_r ? (COL_W'(TCV) - 10'd1 - colraw) : colraw;
  end

  rcw_div_chain #(.DW(DIST_W), .QW(HGT_W), .SW(SBB_W)) u_div_hgt (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .v_in  (s1_v_r),
    .rem_in(24'(SCREEN_ROWS)),
    .dvs_in(s1_dist_r),
    .nb_in ('0),
    .sb_in (sbb_in),
    .v_out (cb_v),
    .q_out (cb_q),
    .sb_out(sbb_bits)
  );

  assign sbb_out = rcw_sbb_t'(sbb_bits);

  // height, draw rows
  logic [HGT_W-1:0] hgt_b;
  logic [16:0]      hh, first17, last17, off17, sum17;
  logic             s2_v_r;
  rcw_sbc_t         s2_sb_r, sbc_nxt;

  always_comb begin
    hgt_b   = (sbb_out.dz || sbb_out.hsat) ? HGT_MAX : cb_q;
    hh      = {2'b00, hgt_b[15:1]};
    sum17   = hh + HALF17;
    first17 = (hh >= HALF17) ? 17'd0 : HALF17 - hh;
    last17  = (sum17 > SR17) ? SR17 : sum17;
    off17   = (hh >= HALF17) ? hh - HALF17 : 17'd0;
    sbc_nxt.wdist = sbb_out.wdist;
    sbc_nxt.hgt   = hgt_b;
    sbc_nxt.first = first17[ROW_W-1:0];
    sbc_nxt.last  = last17[ROW_W-1:0];
    sbc_nxt.tsel  = sbb_out.tsel;
    sbc_nxt.col   = sbb_out.col;
    sbc_nxt.err   = sbb_out.err || sbb_out.dz || (hgt_b == '0);
    sbc_nxt.hz    = (hgt_b == '0);
    sbc_nxt.ssat  = {12'h000, TRV} >= {hgt_b, 7'h00};
    sbc_nxt.off   = off17[15:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (en) begin
      s2_v_r <= cb_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_sb_r <= sbc_nxt;
    end
  end

  // texture step
  logic              cc_v;
  logic [STEP_W-1:0] cc_q;
  logic [SBC_W-1:0]  sbc_bits;
  rcw_sbc_t          sbc_out;
  logic [STEP_W-1:0] step_c;

  rcw_div_chain #(.DW(HGT_W), .QW(STEP_W), .SW(SBC_W)) u_div_step (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .v_in  (s2_v_r),
    .rem_in(16'(TRV >> 7)),
    .dvs_in(s2_sb_r.hgt),
    .nb_in ({TRV[6:0], 16'h0000}),
    .sb_in (s2_sb_r),
    .v_out (cc_v),
    .q_out (cc_q),
    .sb_out(sbc_bits)
  );

  assign sbc_out = rcw_sbc_t'(sbc_bits);
  assign step_c  = (sbc_out.hz || sbc_out.ssat) ? STEP_MAX : cc_q;

  // texture start product
  logic              s3_v_r;
  rcw_sbc_t          s3_sb_r;
  logic [STEP_W-1:0] s3_step_r;
  logic [38:0]       s3_prod_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (en) begin
      s3_v_r <= cc_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_sb_r   <= sbc_out;
      s3_step_r <= step_c;
      s3_prod_r <= sbc_out.off * step_c;
    end
  end

  // output register
  logic [START_W-1:0] start_d;
  logic [119:0]       out_data_r;
  logic               out_err_r;

  assign start_d = s3_sb_r.hz ? '0
                 : (s3_prod_r > 39'(START_MAX)) ? START_MAX : s3_prod_r[START_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= {7'h00, start_d, s3_step_r, s3_sb_r.col[5:0], s3_sb_r.tsel,
                     s3_sb_r.last, s3_sb_r.first, s3_sb_r.hgt, s3_sb_r.wdist};
      out_err_r  <= s3_sb_r.err;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_err_r;

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result request after reset");

  a_dist_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata[23:0] != 24'd0)
    else $error("zero distance without error flag");

  a_step_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata[90:68] != 23'd0)
    else $error("zero texture step without error flag");

  a_hgt_zero_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[39:24] == 16'd0 |-> out_tuser[0])
    else $error("zero height without error flag");

endmodule

### rtl/rcw_div_cell.sv
module rcw_div_cell
  import rcw_pkg::*;
#(
  parameter int DW = 18,
  parameter int QW = 24,
  parameter int SW = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          v_in,
  input  logic [DW-1:0] rem_in,
  input  logic [DW-1:0] dvs_in,
  input  logic [QW-1:0] nb_in,
  input  logic [QW-1:0] q_in,
  input  logic [SW-1:0] sb_in,
  output logic          v_out,
  output logic [DW-1:0] rem_out,
  output logic [DW-1:0] dvs_out,
  output logic [QW-1:0] nb_out,
  output logic [QW-1:0] q_out,
  output logic [SW-1:0] sb_out
);

  logic          v_r;
  logic [DW-1:0] rem_r, rem_nxt;
  logic [DW-1:0] dvs_r;
  logic [QW-1:0] nb_r, nb_nxt;
  logic [QW-1:0] q_r, q_nxt;
  logic [SW-1:0] sb_r;
  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          ge;

  // one restoring step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    trial   = {rem_in, nb_in[QW-1]};
    diff    = trial - {1'b0, dvs_in};
    ge      = trial >= {1'b0, dvs_in};
    rem_nxt = ge ? diff[DW-1:0] : trial[DW-1:0];
    q_nxt   = {q_in[QW-2:0], ge};
    nb_nxt  = {nb_in[QW-2:0], 1'b0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r <= rem_nxt;
      dvs_r <= dvs_in;
      nb_r  <= nb_nxt;
      q_r   <= q_nxt;
      sb_r  <= sb_in;
    end
  end

  assign v_out   = v_r;
  assign rem_out = rem_r;
  assign dvs_out = dvs_r;
  assign nb_out  = nb_r;
  assign q_out   = q_r;
  assign sb_out  = sb_r;

endmodule

### rtl/rcw_div_chain.sv
module rcw_div_chain
  import rcw_pkg::*;
#(
  parameter int DW = 18,
  parameter int QW = 24,
  parameter int SW = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          v_in,
  input  logic [DW-1:0] rem_in,
  input  logic [DW-1:0] dvs_in,
  input  logic [QW-1:0] nb_in,
  input  logic [SW-1:0] sb_in,
  output logic          v_out,
  output logic [QW-1:0] q_out,
  output logic [SW-1:0] sb_out
);

  logic          v_w   [QW+1];
  logic [DW-1:0] rem_w [QW+1];
  logic [DW-1:0] dvs_w [QW+1];
  logic [QW-1:0] nb_w  [QW+1];
  logic [QW-1:0] q_w   [QW+1];
  logic [SW-1:0] sb_w  [QW+1];

  assign v_w[0]   = v_in;
  assign rem_w[0] = rem_in;
  assign dvs_w[0] = dvs_in;
  assign nb_w[0]  = nb_in;
  assign q_w[0]   = '0;
  assign sb_w[0]  = sb_in;

  // one quotient bit per cell, most significant first
  for (genvar i = 0; i < QW; i++) begin : g_cell
    rcw_div_cell #(.DW(DW), .QW(QW), .SW(SW)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .v_in   (v_w[i]),
      .rem_in (rem_w[i]),
      .dvs_in (dvs_w[i]),
      .nb_in  (nb_w[i]),
      .q_in   (q_w[i]),
      .sb_in  (sb_w[i]),
      .v_out  (v_w[i+1]),
      .rem_out(rem_w[i+1]),
      .dvs_out(dvs_w[i+1]),
      .nb_out (nb_w[i+1]),
      .q_out  (q_w[i+1]),
      .sb_out (sb_w[i+1])
    );
  end

  assign v_out  = v_w[QW];
  assign q_out  = q_w[QW];
  assign sb_out = sb_w[QW];

endmodule

### bench/tb_raycast_column_wall_texture_setup_core.sv
module tb_raycast_column_wall_texture_setup_core;
  import rcw_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic               side;
    logic [7:0]         cx;
    logic [7:0]         cy;
    logic signed [1:0]  sx;
    logic signed [1:0]  sy;
    logic [23:0]        ex;
    logic [23:0]        ey;
    logic signed [17:0] rx;
    logic signed [17:0] ry;
  } column_t;

  typedef struct packed {
    logic [23:0] wdist;
    logic [15:0] hgt;
    logic [9:0]  first;
    logic [9:0]  last;
    logic [1:0]  tsel;
    logic [5:0]  col;
    logic [22:0] step;
    logic [21:0] start;
    logic        err;
  } slice_t;

  class slice_scoreboard;
    slice_t pending_slices[$];
    int     errors = 0;

    function slice_t predict_slice(column_t c);
      slice_t s;
      longint hcell, sgn, eye, ray, eye_o, ray_o, num, q, wd, h, first, last, full;
      longint frac, col, step, start, offs;
      logic err;
      err   = 1'b0;
      hcell = longint'(c.side ? c.cy : c.cx);
      sgn   = c.side ? longint'(c.sy) : longint'(c.sx);
      eye   = longint'(c.side ? c.ey : c.ex);
      ray   = c.side ? longint'(c.ry) : longint'(c.rx);
      eye_o = longint'(c.side ? c.ex : c.ey);
      ray_o = c.side ? longint'(c.rx) : longint'(c.ry);
      if (ray == 0) begin
        err = 1'b1;
        wd = 64'hFFFFFF;
      end else begin
        num = hcell * 65536 - eye + (sgn < 0 ? 65536 : 0);
        q = (num * 65536) / ray;
        wd = q < 0 ? 0 : (q > 64'hFFFFFF ? 64'hFFFFFF : q);
      end
      if (wd == 0) begin
        err = 1'b1;
        h = 65535;
      end else begin
        h = (longint'(512) * 65536) / wd;
        if (h > 65535) h = 65535;
      end
      first = 256 - h / 2;
      if (first < 0) first = 0;
      last = h / 2 + 256;
      if (last > 512) last = 512;
      s.tsel = c.side ? TSEL_Y_POS : TSEL_X_POS;
      if (ray < 0) s.tsel = c.side ? TSEL_Y_NEG : TSEL_X_NEG;
      full = eye_o * 65536 + wd * ray_o;
      frac = (full >> 16) & 64'hFFFF;
      col = (frac * 64) >> 16;
      if ((!c.side && c.rx > 0) || (c.side && c.ry < 0)) col = 64 - col - 1;
      if (h == 0) begin
        err = 1'b1;
        step = 64'h7FFFFF;
        start = 0;
      end else begin
        step = (longint'(64) << 16) / h;
        if (step > 64'h7FFFFF) step = 64'h7FFFFF;
        offs = first - 256 + h / 2;
        start = offs * step;
        if (start > 64'h3FFFFF) start = 64'h3FFFFF;
      end
      s.wdist = wd[23:0];
      s.hgt = h[15:0];
      s.first = first[9:0];
      s.last = last[9:0];
      s.col = col[5:0];
      s.step = step[22:0];
      s.start = start[21:0];
      s.err = err;
      return s;
    endfunction

    function void note_request(column_t c);
      pending_slices.push_back(predict_slice(c));
    endfunction

    function void check_result(slice_t got);
      slice_t e;
      if (pending_slices.size() == 0) begin
        $display("%0t unexpected result dist=%h", $time, got.wdist);
        errors++;
        return;
      end
      e = pending_slices.pop_front();
      if (e != got) begin
        $display("%0t expected dist=%h hgt=%h first=%h last=%h tsel=%h col=%h",
                 $time, e.wdist, e.hgt, e.first, e.last, e.tsel, e.col);
        $display("%0t expected step=%h start=%h err=%b", $time, e.step, e.start, e.err);
        $display("%0t actual   dist=%h hgt=%h first=%h last=%h tsel=%h col=%h",
                 $time, got.wdist, got.hgt, got.first, got.last, got.tsel, got.col);
        $display("%0t actual   step=%h start=%h err=%b", $time, got.step, got.start,
                 got.err);
        errors++;
      end
    endfunction
  endclass

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [103:0] in_tdata;
  logic [0:0]   in_tuser;
  logic         out_tvalid;
  logic         out_tready;
  logic [119:0] out_tdata;
  logic [0:0]   out_tuser;

  raycast_column_wall_texture_setup_core DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  slice_scoreboard sb = new();
  column_t   queued_columns[$];
  column_t   column_on_bus;
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;
  logic      recv_hold = 1'b0;
  int        quiet_cycles = 0;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function logic [103:0] pack_column(column_t c);
    return {c.ry, c.rx, c.ey, c.ex, c.sy, c.sx, c.cy, c.cx};
  endfunction

  initial begin
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    out_tready = 1'b0;
  end

  // request side
  always @(posedge clk) begin
    logic next_valid;
    column_t c;
    next_valid = in_tvalid;
    if (in_tvalid && in_tready) begin
      sb.note_request(column_on_bus);
      next_valid = 1'b0;
    end
    if (rst_n && !next_valid && queued_columns.size() > 0 &&
        $urandom_range(99) >= send_idle_pct) begin
      c = queued_columns.pop_front();
      column_on_bus <= c;
      in_tdata <= pack_column(c);
      in_tuser <= c.side;
      next_valid = 1'b1;
    end
    in_tvalid <= next_valid;
  end

  // result side
  always @(posedge clk) begin
    slice_t r;
    if (out_tvalid && out_tready) begin
      {r.start, r.step, r.col, r.tsel, r.last, r.first, r.hgt, r.wdist} = out_tdata[112:0];
      r.err = out_tuser[0];
      sb.check_result(r);
    end
    out_tready <= rst_n && !recv_hold && ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 4000) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function column_t make_column(logic side, int cx, int cy, int sx, int sy,
                                int ex, int ey, int rx, int ry);
    column_t c;
    c.side = side; c.cx = 8'(cx); c.cy = 8'(cy); c.sx = 2'(sx); c.sy = 2'(sy);
    c.ex = 24'(ex); c.ey = 24'(ey); c.rx = 18'(rx); c.ry = 18'(ry);
    return c;
  endfunction

  function column_t random_column();
    column_t c;
    int k;
    c.side = 1'($urandom_range(1));
    c.cx = 8'($urandom); c.cy = 8'($urandom);
    c.ex = 24'($urandom); c.ey = 24'($urandom);
    c.rx = 18'($urandom); c.ry = 18'($urandom);
    c.sx = $urandom_range(9) == 0 ? 2'($urandom) : ($urandom_range(1) ? 2'sd1 : -2'sd1);
    c.sy = $urandom_range(9) == 0 ? 2'($urandom) : ($urandom_range(1) ? 2'sd1 : -2'sd1);
    k = $urandom_range(9);
    if (k < 7) begin
      // eye a few cells from the hit; for some, ray components within +-65536
      c.ex = 24'(((c.cx + $urandom_range(8) - 4) << 16) | $urandom_range(16'hFFFF));
      c.ey = 24'(((c.cy + $urandom_range(8) - 4) << 16) | $urandom_range(16'hFFFF));
      if (k < 3) begin
        c.rx = 18'($signed(18'($urandom_range(2 * 65536))) - 65536);
        c.ry = 18'($signed(18'($urandom_range(2 * 65536))) - 65536);
      end
    end
    if ($urandom_range(29) == 0) c.rx = '0;
    if ($urandom_range(29) == 0) c.ry = '0;
    return c;
  endfunction

  task run_phase(int idle, int stall, int count);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    repeat (count) queued_columns.push_back(random_column());
    wait (queued_columns.size() == 0 && !in_tvalid && sb.pending_slices.size() == 0);
  endtask

  initial begin
    rst_n = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    // zero rays, zero distance, odd signs, extremes
    queued_columns.push_back(make_column(0, 5, 5, 1, 1, 3 << 16, 3 << 16, 0, 1000));
    queued_columns.push_back(make_column(1, 5, 5, 1, 1, 3 << 16, 3 << 16, 1000, 0));
    queued_columns.push_back(make_column(0, 4, 2, 1, 1, 4 << 16, 2 << 16, 500, 700));
    queued_columns.push_back(make_column(1, 4, 2, -1, -1, 4 << 16, 3 << 16, 500, -700));
    queued_columns.push_back(make_column(0, 7, 2, -2, 0, 3 << 16, 2 << 16, 65536, 300));
    queued_columns.push_back(make_column(1, 7, 9, 0, -2, 3 << 16, 2 << 16, -300, 65536));
    queued_columns.push_back(make_column(0, 255, 0, 1, 1, 0, 24'hFFFFFF, 1, 131071));
    queued_columns.push_back(make_column(1, 0, 255, 1, 1, 24'hFFFFFF, 0, -131072, 1));
    queued_columns.push_back(make_column(0, 0, 0, -1, 1, 24'hFFFFFF, 0, -131072, -131072));
    queued_columns.push_back(make_column(1, 255, 255, 1, -1, 0, 24'hFFFFFF, 131071, 131071));
    queued_columns.push_back(make_column(0, 10, 3, 1, 1, 9 << 16, 0, 65536, -65536));
    queued_columns.push_back(make_column(0, 10, 3, 1, 1, (9 << 16) + 65535, 0, 65536, 0));
    queued_columns.push_back(make_column(1, 3, 10, 1, -1, 5 << 16, (10 << 16) + 5, 2, -3));
    queued_columns.push_back(make_column(1, 3, 10, 1, 1, 5 << 16, 1 << 16, -77, 131071));
    wait (queued_columns.size() == 0 && !in_tvalid);
    // long receiver hold while the sender keeps offering
    fork
      begin
        recv_hold = 1'b1;
        repeat (400) @(posedge clk);
        recv_hold = 1'b0;
      end
    join_none
    run_phase(0, 0, 410);
    run_phase(53, 0, 410);
    run_phase(0, 53, 410);
    run_phase(18, 18, 410);
    repeat (100) @(posedge clk);
    if (sb.errors == 0 && sb.pending_slices.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
